// ----- rtl/core/pnv_pkg.sv -----
// Package for the partition name validator: reason codes, reserved words,
// and byte classification functions. No dependencies.

package pnv_pkg;

	localparam int MAX_LEN_DEF = 128;
	localparam int DEFAULT_LEN = 7;
	localparam int PREFIX_LEN = 10;

	typedef logic [1:0] reason_t;

	localparam reason_t RSN_CHARSET = 2'd0;
	localparam reason_t RSN_NO_ALNUM = 2'd1;
	localparam reason_t RSN_RESERVED = 2'd2;
	localparam reason_t RSN_PREFIX = 2'd3;

	localparam logic [7:0] CH_DOT = 8'h2e;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_DASH = 8'h2d;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5a);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h30) && (c <= 8'h39));
	endfunction

	function automatic logic is_allowed(input logic [7:0] c);
		return is_alnum(c) || (c == CH_DOT) || (c == CH_UNDERSCORE) || (c == CH_DASH);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return is_upper(c) ? (c + 8'd32) : c;
	endfunction

	// "default"
	function automatic logic [7:0] default_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h64;
			3'd1: c = 8'h65;
			3'd2: c = 8'h66;
			3'd3: c = 8'h61;
			3'd4: c = 8'h75;
			3'd5: c = 8'h6c;
			3'd6: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "ephemeral-"
	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = 8'h65;
			4'd1: c = 8'h70;
			4'd2: c = 8'h68;
			4'd3: c = 8'h65;
			4'd4: c = 8'h6d;
			4'd5: c = 8'h65;
			4'd6: c = 8'h72;
			4'd7: c = 8'h61;
			4'd8: c = 8'h6c;
			4'd9: c = 8'h2d;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/core/partition_name_validator.sv -----
// Partition name validator: takes one name byte per transaction (none with
// empty_name) and reports validity and the first failing rule on the final
// transaction of a name. A final transaction passes the input stage and then
// the result register, which loads only when no stalled result holds the output.
// Throughput: one transaction per cycle, set by the single input stage feeding
// the name state and result register, except when out_stall holds a result back.
// Reset: arst_n resets the name state and clears the input and output valid flags.
// Depends on pnv_pkg.

module partition_name_validator import pnv_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       last,
	input  logic       empty_name,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       valid_res,
	output reason_t    reason
);

	localparam int CNT_W = $clog2(MAX_LEN + 2);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_LEN + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
	localparam logic [CNT_W-1:0] CNT_DEF = CNT_W'(DEFAULT_LEN);
	localparam logic [CNT_W-1:0] CNT_PFX = CNT_W'(PREFIX_LEN);
	localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic             vld_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;
	logic             empty_s1;

	logic [CNT_W-1:0] count_q;
	logic             bad_q;
	logic             alnum_q;
	logic             dots_q;
	logic             def_q;
	logic             pfx_q;

	logic             out_vld_q;
	logic             valid_res_q;
	reason_t          reason_q;

	logic             emit;
	logic             adv;
	logic             take;
	logic [CNT_W-1:0] n_count;
	logic             n_bad;
	logic             n_alnum;
	logic             n_dots;
	logic             n_def;
	logic             n_pfx;
	logic             r_valid;
	reason_t          r_reason;

	assign emit = empty_s1 || last_s1;
	assign adv = vld_s1 && (!emit || !out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !adv;
	assign take = !empty_s1;

	always_comb begin
		n_count = count_q;
		n_bad = bad_q;
		n_alnum = alnum_q;
		n_dots = dots_q;
		n_def = def_q;
		n_pfx = pfx_q;
		if (take) begin
			if (!is_allowed(ch_s1))
				n_bad = 1'b1;
			if (is_alnum(ch_s1))
				n_alnum = 1'b1;
			if (ch_s1 != CH_DOT)
				n_dots = 1'b0;
			if (count_q < CNT_DEF) begin
				if (to_lower(ch_s1) != default_char(count_q[2:0]))
					n_def = 1'b0;
			end else begin
				n_def = 1'b0;
			end
			if ((count_q < CNT_PFX) && (ch_s1 != prefix_char(count_q[3:0])))
				n_pfx = 1'b0;
			if (count_q < CNT_SAT)
				n_count = count_q + CNT_ONE;
		end
	end

	always_comb begin
		r_valid = 1'b0;
		r_reason = RSN_CHARSET;
		if ((n_count == '0) || (n_count > CNT_MAX) || n_bad) begin
			r_reason = RSN_CHARSET;
		end else if (!n_alnum) begin
			r_reason = RSN_NO_ALNUM;
		end else if ((n_dots && (n_count <= CNT_TWO)) || (n_def && (n_count == CNT_DEF))) begin
			r_reason = RSN_RESERVED;
		end else if (n_pfx && (n_count >= CNT_PFX)) begin
			r_reason = RSN_PREFIX;
		end else begin
			r_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!vld_s1 || adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1 <= ch;
			last_s1 <= last;
			empty_s1 <= empty_name;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bad_q <= 1'b0;
			alnum_q <= 1'b0;
			dots_q <= 1'b1;
			def_q <= 1'b1;
			pfx_q <= 1'b1;
		end else if (adv) begin
			if (emit) begin
				count_q <= '0;
				bad_q <= 1'b0;
				alnum_q <= 1'b0;
				dots_q <= 1'b1;
				def_q <= 1'b1;
				pfx_q <= 1'b1;
			end else begin
				count_q <= n_count;
				bad_q <= n_bad;
				alnum_q <= n_alnum;
				dots_q <= n_dots;
				def_q <= n_def;
				pfx_q <= n_pfx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			valid_res_q <= r_valid;
			reason_q <= r_reason;
		end
	end

	assign out_valid = out_vld_q;
	assign valid_res = valid_res_q;
	assign reason = reason_q;

endmodule
